[hdl/qrs_pkg.sv]
`default_nettype none

package qrs_pkg;

  // Coefficient format: signed fixed point, CW bits with FB fraction bits.
  localparam int CW  = 32;
  localparam int FB  = 16;
  localparam int TW  = 16;          // coefficient tolerance register
  localparam int DTW = 32;          // discriminant tolerance register

  // Derived datapath widths.
  localparam int PW  = 2 * CW;      // b*b and a*c products
  localparam int DW  = 2 * CW + 2;  // discriminant magnitude
  localparam int SW  = CW + 1;      // square root of the discriminant
  localparam int DNW = CW + 1;      // divisor magnitude (2|a| or |b|)
  localparam int NMW = CW + 2;      // numerator magnitude (|b| + sqrt)
  localparam int SNW = NMW + 1;     // signed numerator
  localparam int NDW = NMW + FB + 1; // dividend, numerator scaled by 2^(FB+1)
  localparam int QB  = CW + 1;      // quotient bits before rounding
  localparam int CMW = NDW + DNW;   // width for the quotient range check

  // Result classification.
  typedef enum logic [2:0] {
    ST_TWO_REAL = 3'd0,
    ST_ONE_REAL = 3'd1,
    ST_COMPLEX  = 3'd2,
    ST_ANY_X    = 3'd3,
    ST_NO_ROOT  = 3'd4
  } status_e;

  // Per-item context carried alongside the square root and divider.
  typedef struct packed {
    status_e        status;
    logic [CW-1:0]  nb;      // magnitude of the base numerator (-b or -c)
    logic           nb_neg;  // base numerator is negative
    logic [DNW-1:0] dm;      // divisor magnitude
    logic           dn_neg;  // divisor is negative
  } ctx_t;

  // One result beat.
  typedef struct packed {
    status_e       status;
    logic [CW-1:0] first_real;
    logic [CW-1:0] first_imag;
    logic [CW-1:0] second_real;
    logic [CW-1:0] second_imag;
    logic          overflow;
  } res_t;

  // Magnitude of a two's complement coefficient; the most negative value maps to 2^(CW-1).
  function automatic logic [CW-1:0] coef_mag(input logic [CW-1:0] x);
    return x[CW-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

`default_nettype wire

[hdl/qrs_front.sv]
`default_nettype none

module qrs_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [qrs_pkg::CW-1:0]    coef_a_i,
  input  wire logic [qrs_pkg::CW-1:0]    coef_b_i,
  input  wire logic [qrs_pkg::CW-1:0]    coef_c_i,
  input  wire logic [qrs_pkg::TW-1:0]    coef_tol_i,
  input  wire logic [qrs_pkg::DTW-1:0]   disc_tol_i,
  output logic                           valid_o,
  output logic [qrs_pkg::DW-1:0]         d_o,
  output qrs_pkg::ctx_t                  ctx_o
);

  localparam int CW  = qrs_pkg::CW;
  localparam int TW  = qrs_pkg::TW;
  localparam int PW  = qrs_pkg::PW;
  localparam int DW  = qrs_pkg::DW;
  localparam int DNW = qrs_pkg::DNW;
  localparam int DTW = qrs_pkg::DTW;

  // Coefficient magnitudes, signs and tolerance flags.
  typedef struct packed {
    logic [CW-1:0] am;
    logic [CW-1:0] bm;
    logic [CW-1:0] cm;
    logic          an;
    logic          bn;
    logic          bp;
    logic          cp;
    logic          a_sm;
    logic          b_sm;
    logic          c_sm;
  } coef_t;

  logic          v0_q, v1_q, v2_q, v3_q;
  logic [CW-1:0] am0_q, bm0_q, cm0_q;
  logic          an0_q, bn0_q, cn0_q;
  coef_t         c1_q, c2_q;
  coef_t         c1_d;
  logic [PW-1:0] bb1_q, ac1_q;
  logic          acn1_q;
  logic [DW-1:0] d2_q, d2_d;
  logic          dn2_q, dn2_d;
  logic [DW-1:0] d3_q;
  qrs_pkg::ctx_t ctx3_q, ctx3_d;

  logic [DW-1:0] ac4, bbx, d_sum, d_fwd, d_rev;
  logic          disc_small;

  // Valid bits move with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1 flags: tolerance tests and signs.
  always_comb begin
    c1_d.am   = am0_q;
    c1_d.bm   = bm0_q;
    c1_d.cm   = cm0_q;
    c1_d.an   = an0_q;
    c1_d.bn   = bn0_q;
    c1_d.bp   = !bn0_q && (bm0_q != '0);
    c1_d.cp   = !cn0_q && (cm0_q != '0);
    c1_d.a_sm = (CW+TW)'(am0_q) < (CW+TW)'(coef_tol_i);
    c1_d.b_sm = (CW+TW)'(bm0_q) < (CW+TW)'(coef_tol_i);
    c1_d.c_sm = (CW+TW)'(cm0_q) < (CW+TW)'(coef_tol_i);
  end

  // Stage 2: discriminant magnitude and sign from the two products.
  always_comb begin
    ac4   = {ac1_q, 2'b00};
    bbx   = DW'(bb1_q);
    d_sum = bbx + ac4;
    d_fwd = bbx - ac4;
    d_rev = ac4 - bbx;
    if (acn1_q) begin
      d2_d  = d_sum;
      dn2_d = 1'b0;
    end else if (bbx >= ac4) begin
      d2_d  = d_fwd;
      dn2_d = 1'b0;
    end else begin
      d2_d  = d_rev;
      dn2_d = 1'b1;
    end
  end

  // Stage 3: classify the equation and pick numerator and divisor.
  always_comb begin
    disc_small    = (DW+DTW)'(d2_q) < (DW+DTW)'(disc_tol_i);
    ctx3_d.status = qrs_pkg::ST_TWO_REAL;
    ctx3_d.nb     = c2_q.bm;
    ctx3_d.nb_neg = c2_q.bp;
    ctx3_d.dm     = {c2_q.am, 1'b0};
    ctx3_d.dn_neg = c2_q.an;
    if (c2_q.a_sm) begin
      ctx3_d.nb     = c2_q.cm;
      ctx3_d.nb_neg = c2_q.cp;
      ctx3_d.dm     = DNW'(c2_q.bm);
      ctx3_d.dn_neg = c2_q.bn;
      if (c2_q.b_sm) begin
        ctx3_d.status = c2_q.c_sm ? qrs_pkg::ST_ANY_X : qrs_pkg::ST_NO_ROOT;
      end else begin
        ctx3_d.status = qrs_pkg::ST_ONE_REAL;
      end
    end else if (disc_small) begin
      ctx3_d.status = qrs_pkg::ST_ONE_REAL;
    end else if (dn2_q) begin
      ctx3_d.status = qrs_pkg::ST_COMPLEX;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am0_q  <= qrs_pkg::coef_mag(coef_a_i);
      bm0_q  <= qrs_pkg::coef_mag(coef_b_i);
      cm0_q  <= qrs_pkg::coef_mag(coef_c_i);
      an0_q  <= coef_a_i[CW-1];
      bn0_q  <= coef_b_i[CW-1];
      cn0_q  <= coef_c_i[CW-1];
      c1_q   <= c1_d;
      bb1_q  <= PW'(bm0_q) * PW'(bm0_q);
      ac1_q  <= PW'(am0_q) * PW'(cm0_q);
      acn1_q <= (an0_q ^ cn0_q) && (am0_q != '0) && (cm0_q != '0);
      c2_q   <= c1_q;
      d2_q   <= d2_d;
      dn2_q  <= dn2_d;
      d3_q   <= d2_q;
      ctx3_q <= ctx3_d;
    end
  end

  assign valid_o = v3_q;
  assign d_o     = d3_q;
  assign ctx_o   = ctx3_q;

endmodule

`default_nettype wire

[hdl/qrs_sqrt.sv]
`default_nettype none

module qrs_sqrt (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [qrs_pkg::DW-1:0] d_i,
  input  wire qrs_pkg::ctx_t          ctx_i,
  output logic                        valid_o,
  output logic [qrs_pkg::SW-1:0]      root_o,
  output qrs_pkg::ctx_t               ctx_o
);

  localparam int DW = qrs_pkg::DW;
  localparam int SW = qrs_pkg::SW;

  // Partial root and the remainder d - root^2.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [SW-1:0] r;
  } sq_t;

  // One root bit: keep it when (r + 2^b)^2 still fits under d.
  function automatic sq_t sqrt_step(input sq_t s, input int unsigned b);
    logic [DW:0] trial;
    sq_t         o;
    trial = ((DW+1)'(s.r) << (b + 1)) + ((DW+1)'(1) << (2 * b));
    o     = s;
    if ({1'b0, s.rem} >= trial) begin
      o.rem = DW'({1'b0, s.rem} - trial);
      o.r   = s.r | (SW'(1) << b);
    end
    return o;
  endfunction

  logic          v_q   [SW];
  sq_t           sq_q  [SW];
  qrs_pkg::ctx_t ctx_q [SW];
  sq_t           sq_in;
  logic          rv_q;
  logic [SW-1:0] root_q, root_d;
  qrs_pkg::ctx_t rctx_q;

  assign sq_in.rem = d_i;
  assign sq_in.r   = '0;

  // Valid bits, one per bit stage plus the rounding stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SW; k++) begin
        v_q[k] <= 1'b0;
      end
      rv_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < SW; k++) begin
        v_q[k] <= v_q[k-1];
      end
      rv_q <= v_q[SW-1];
    end
  end

  // Round to nearest: bump the root when the remainder exceeds it.
  assign root_d = (sq_q[SW-1].rem > DW'(sq_q[SW-1].r)) ? sq_q[SW-1].r + 1'b1
                                                      : sq_q[SW-1].r;

  // One root bit per stage, most significant first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0]  <= sqrt_step(sq_in, SW - 1);
      ctx_q[0] <= ctx_i;
      for (int k = 1; k < SW; k++) begin
        sq_q[k]  <= sqrt_step(sq_q[k-1], (SW - 1 - k));
        ctx_q[k] <= ctx_q[k-1];
      end
      root_q <= root_d;
      rctx_q <= ctx_q[SW-1];
    end
  end

  assign valid_o = rv_q;
  assign root_o  = root_q;
  assign ctx_o   = rctx_q;

endmodule

`default_nettype wire

[hdl/qrs_div.sv]
`default_nettype none

module qrs_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [qrs_pkg::SW-1:0] root_i,
  input  wire qrs_pkg::ctx_t          ctx_i,
  output logic                        valid_o,
  output qrs_pkg::res_t               res_o
);

  localparam int CW  = qrs_pkg::CW;
  localparam int FB  = qrs_pkg::FB;
  localparam int DNW = qrs_pkg::DNW;
  localparam int NMW = qrs_pkg::NMW;
  localparam int SNW = qrs_pkg::SNW;
  localparam int NDW = qrs_pkg::NDW;
  localparam int QB  = qrs_pkg::QB;
  localparam int CMW = qrs_pkg::CMW;

  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // One restoring divider lane.
  typedef struct packed {
    logic [DNW-1:0] rem;
    logic [QB-1:0]  lo;
    logic [QB-1:0]  q;
  } lane_t;

  // Flags that ride along with both lanes.
  typedef struct packed {
    logic          big_x;
    logic          big_y;
    logic          neg_x;
    logic          neg_y;
    logic          nz_y;
    qrs_pkg::ctx_t ctx;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] val;
    logic          ovf;
  } sat_t;

  // One quotient bit.
  function automatic lane_t div_step(input lane_t l, input logic [DNW-1:0] dm);
    logic [DNW:0] t;
    logic         ge;
    lane_t        o;
    t     = {l.rem, l.lo[QB-1]};
    ge    = t >= {1'b0, dm};
    o.rem = ge ? DNW'(t - {1'b0, dm}) : DNW'(t);
    o.lo  = l.lo << 1;
    o.q   = {l.q[QB-2:0], ge};
    return o;
  endfunction

  // Round the half-LSB quotient and clamp it to the signed coefficient range.
  function automatic sat_t fit(input logic [QB-1:0] q, input logic big, input logic neg,
                               input logic num_neg, input logic dz);
    logic [QB:0]   qr;
    logic [QB-1:0] qm;
    logic [QB-1:0] lim;
    logic [QB-1:0] negq;
    sat_t          r;
    qr    = {1'b0, q} + 1'b1;
    qm    = qr[QB:1];
    lim   = QB'(1) << (CW - 1);
    negq  = -qm;
    r.val = '0;
    r.ovf = 1'b0;
    if (dz) begin
      r.ovf = 1'b1;
      r.val = num_neg ? MINV : MAXV;
    end else if (big || (qm != '0)) begin
      if (neg) begin
        if (big || (qm > lim)) begin
          r.ovf = 1'b1;
          r.val = MINV;
        end else begin
          r.val = negq[CW-1:0];
        end
      end else begin
        if (big || (qm > (lim - 1'b1))) begin
          r.ovf = 1'b1;
          r.val = MAXV;
        end else begin
          r.val = qm[CW-1:0];
        end
      end
    end
    return r;
  endfunction

  // Stage 1 signals.
  logic signed [SNW-1:0] base, sval, nx, ny;
  logic                  v1_q;
  logic [NMW-1:0]        xm1_q, ym1_q;
  logic                  xn1_q, yn1_q;
  qrs_pkg::ctx_t         ctx1_q;

  // Stage 2 signals.
  logic [NDW-1:0]        xd, yd;
  lane_t                 lx_in, ly_in;
  side_t                 side_in;

  // Divider stages; index 0 is the loaded operand.
  logic                  v_q    [QB+1];
  lane_t                 lx_q   [QB+1];
  lane_t                 ly_q   [QB+1];
  side_t                 side_q [QB+1];

  // Output stage.
  sat_t                  sx, sy, si1, si2;
  logic                  dz, dn;
  logic                  fv_q;
  qrs_pkg::res_t         res_q, res_d;

  // Signed numerators from -b (or -c) and the square root.
  always_comb begin
    base = $signed(SNW'(ctx_i.nb));
    if (ctx_i.nb_neg) begin
      base = -base;
    end
    sval = $signed(SNW'(root_i));
    case (ctx_i.status)
      qrs_pkg::ST_TWO_REAL: begin
        nx = base - sval;
        ny = base + sval;
      end
      qrs_pkg::ST_COMPLEX: begin
        nx = base;
        ny = sval;
      end
      default: begin
        nx = base;
        ny = '0;
      end
    endcase
  end

  // Scale the numerators, load the top dividend bits and flag quotients that cannot fit.
  always_comb begin
    xd               = NDW'(xm1_q) << (FB + 1);
    yd               = NDW'(ym1_q) << (FB + 1);
    lx_in.rem        = DNW'(xd >> QB);
    lx_in.lo         = xd[QB-1:0];
    lx_in.q          = '0;
    ly_in.rem        = DNW'(yd >> QB);
    ly_in.lo         = yd[QB-1:0];
    ly_in.q          = '0;
    side_in.big_x    = CMW'(xd >> QB) >= CMW'(ctx1_q.dm);
    side_in.big_y    = CMW'(yd >> QB) >= CMW'(ctx1_q.dm);
    side_in.neg_x    = xn1_q;
    side_in.neg_y    = yn1_q;
    side_in.nz_y     = ym1_q != '0;
    side_in.ctx      = ctx1_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        v_q[k] <= 1'b0;
      end
      fv_q <= 1'b0;
    end else if (en_i) begin
      v1_q   <= valid_i;
      v_q[0] <= v1_q;
      for (int k = 1; k <= QB; k++) begin
        v_q[k] <= v_q[k-1];
      end
      fv_q <= v_q[QB];
    end
  end

  // Final rounding, saturation and result assembly.
  always_comb begin
    dz  = side_q[QB].ctx.dm == '0;
    dn  = side_q[QB].ctx.dn_neg;
    sx  = fit(lx_q[QB].q, side_q[QB].big_x, side_q[QB].neg_x ^ dn, side_q[QB].neg_x, dz);
    sy  = fit(ly_q[QB].q, side_q[QB].big_y, side_q[QB].neg_y ^ dn, side_q[QB].neg_y, dz);
    si1 = fit(ly_q[QB].q, side_q[QB].big_y, side_q[QB].nz_y ^ dn, side_q[QB].nz_y, dz);
    si2 = fit(ly_q[QB].q, side_q[QB].big_y, dn, 1'b0, dz);
    res_d             = '0;
    res_d.status      = side_q[QB].ctx.status;
    case (side_q[QB].ctx.status)
      qrs_pkg::ST_TWO_REAL: begin
        res_d.first_real  = sx.val;
        res_d.second_real = sy.val;
        res_d.overflow    = sx.ovf | sy.ovf;
      end
      qrs_pkg::ST_ONE_REAL: begin
        res_d.first_real  = sx.val;
        res_d.overflow    = sx.ovf;
      end
      qrs_pkg::ST_COMPLEX: begin
        res_d.first_real  = sx.val;
        res_d.second_real = sx.val;
        res_d.first_imag  = si1.val;
        res_d.second_imag = si2.val;
        res_d.overflow    = sx.ovf | si1.ovf | si2.ovf;
      end
      default: begin
        res_d.overflow    = 1'b0;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm1_q  <= NMW'(nx[SNW-1] ? -nx : nx);
      ym1_q  <= NMW'(ny[SNW-1] ? -ny : ny);
      xn1_q  <= nx[SNW-1];
      yn1_q  <= ny[SNW-1];
      ctx1_q <= ctx_i;
      lx_q[0]   <= lx_in;
      ly_q[0]   <= ly_in;
      side_q[0] <= side_in;
      for (int k = 1; k <= QB; k++) begin
        lx_q[k]   <= div_step(lx_q[k-1], side_q[k-1].ctx.dm);
        ly_q[k]   <= div_step(ly_q[k-1], side_q[k-1].ctx.dm);
        side_q[k] <= side_q[k-1];
      end
      res_q <= res_d;
    end
  end

  assign valid_o = fv_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[hdl/quadratic_root_solver.sv]
`default_nettype none

// Quadratic root solver for signed Q16.16 coefficients a, b, c. Each accepted beat
// returns one result beat with a status code, up to two roots (real and imaginary
// parts, Q16.16, saturated) and an overflow flag. The block is a fully pipelined
// datapath: a new coefficient beat can be accepted every clock cycle while the
// pipeline is not stalled. It is built from one-bit stages: 33 square root stages
// and 33 divider stages, plus front-end multiply and discriminant stages. A
// two-entry output buffer keeps input ready registered, so backpressure on the
// result side stalls the whole pipeline in the cycle after a beat meets a full
// output register, without losing or repeating beats. Tolerance registers are
// written through the APB port at byte addresses 0 (coefficient tolerance) and 4
// (discriminant tolerance) and must only be changed while the pipeline is empty.
module quadratic_root_solver (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Coefficient channel.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [qrs_pkg::CW-1:0]  coef_a_i,
  input  wire logic signed [qrs_pkg::CW-1:0]  coef_b_i,
  input  wire logic signed [qrs_pkg::CW-1:0]  coef_c_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          status_o,
  output logic signed [qrs_pkg::CW-1:0]       first_real_o,
  output logic signed [qrs_pkg::CW-1:0]       first_imag_o,
  output logic signed [qrs_pkg::CW-1:0]       second_real_o,
  output logic signed [qrs_pkg::CW-1:0]       second_imag_o,
  output logic                                overflow_o,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int TW  = qrs_pkg::TW;
  localparam int DTW = qrs_pkg::DTW;

  localparam logic REG_COEF_TOL = 1'b0;
  localparam logic REG_DISC_TOL = 1'b1;

  localparam logic [TW-1:0]  COEF_TOL_RST = TW'(1);
  localparam logic [DTW-1:0] DISC_TOL_RST = DTW'(4295);

  logic [TW-1:0]           coef_tol_q;
  logic [DTW-1:0]          disc_tol_q;
  logic                    cfg_wr;

  logic                    en;
  logic                    f_valid;
  logic [qrs_pkg::DW-1:0]  f_d;
  qrs_pkg::ctx_t           f_ctx;
  logic                    s_valid;
  logic [qrs_pkg::SW-1:0]  s_root;
  qrs_pkg::ctx_t           s_ctx;
  logic                    x_valid;
  qrs_pkg::res_t           x_res;

  logic                    out_v_q, skid_v_q;
  qrs_pkg::res_t           out_q, skid_q;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_tol_q <= COEF_TOL_RST;
      disc_tol_q <= DISC_TOL_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_COEF_TOL: coef_tol_q <= pwdata[TW-1:0];
        REG_DISC_TOL: disc_tol_q <= pwdata[DTW-1:0];
        default:      coef_tol_q <= coef_tol_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COEF_TOL: prdata = 32'(coef_tol_q);
      REG_DISC_TOL: prdata = 32'(disc_tol_q);
      default:      prdata = '0;
    endcase
  end

  // The pipeline advances whenever the skid entry is free.
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  qrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .coef_a_i   (coef_a_i),
    .coef_b_i   (coef_b_i),
    .coef_c_i   (coef_c_i),
    .coef_tol_i (coef_tol_q),
    .disc_tol_i (disc_tol_q),
    .valid_o    (f_valid),
    .d_o        (f_d),
    .ctx_o      (f_ctx)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .d_i     (f_d),
    .ctx_i   (f_ctx),
    .valid_o (s_valid),
    .root_o  (s_root),
    .ctx_o   (s_ctx)
  );

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .root_i  (s_root),
    .ctx_i   (s_ctx),
    .valid_o (x_valid),
    .res_o   (x_res)
  );

  // Output register with a skid entry that catches the beat leaving the pipeline
  // during the cycle in which a stall is first seen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (!out_v_q || out_ready_i) begin
        out_v_q <= x_valid;
      end else if (x_valid) begin
        skid_v_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_v_q || out_ready_i) begin
        out_q <= x_res;
      end else begin
        skid_q <= x_res;
      end
    end else if (out_ready_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = out_q.status;
  assign first_real_o  = out_q.first_real;
  assign first_imag_o  = out_q.first_imag;
  assign second_real_o = out_q.second_real;
  assign second_imag_o = out_q.second_imag;
  assign overflow_o    = out_q.overflow;

endmodule

`default_nettype wire

[bench/quadratic_root_solver_test.sv]
`default_nettype none

module quadratic_root_solver_test;

  localparam int CW  = qrs_pkg::CW;
  localparam int FB  = qrs_pkg::FB;
  localparam int TW  = qrs_pkg::TW;
  localparam int DTW = qrs_pkg::DTW;

  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 4000;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_COEF_TOL = 3'd0;
  localparam logic [2:0] ADDR_DISC_TOL = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] coef_a_i = '0, coef_b_i = '0, coef_c_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic signed [CW-1:0] first_real_o, first_imag_o, second_real_o, second_imag_o;
  logic overflow_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quadratic_root_solver u_top (.*);

  always #1 clk_i = ~clk_i;

  // Solver-side copy of the tolerance registers.
  logic [TW-1:0]  coef_tol;
  logic [DTW-1:0] disc_tol;

  qrs_pkg::res_t root_queue[$];
  int   errors;
  int   beats_sent;
  int   roots_seen;
  int   status_count[5];
  bit   stim_done;
  bit   stall_mode;

  // Rounded, saturated fixed-point quotient num/den.
  function automatic logic [CW-1:0] fx_ratio(input logic signed [127:0] num,
                                             input logic signed [127:0] den,
                                             inout logic ovf);
    logic [127:0] nm, dm, q, qm;
    logic neg;
    nm  = num < 0 ? -num : num;
    dm  = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    if (dm == 0) begin
      ovf = 1'b1;
      return num < 0 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    q = (nm << (FB + 1)) / dm;
    if (q >> 62 != 0) qm = 128'h3FFF_FFFF_FFFF_FFFF;
    else qm = (q + 1) >> 1;
    if (qm == 0) return '0;
    if (neg) begin
      if (qm > (128'd1 << (CW-1))) begin
        ovf = 1'b1;
        qm = 128'd1 << (CW-1);
      end
      return -qm[CW-1:0];
    end
    if (qm > (128'd1 << (CW-1)) - 1) begin
      ovf = 1'b1;
      qm = (128'd1 << (CW-1)) - 1;
    end
    return qm[CW-1:0];
  endfunction

  // Integer square root rounded to nearest.
  function automatic logic [127:0] round_sqrt(input logic [127:0] d);
    logic [127:0] r, t;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= d) r = t;
    end
    if (d - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic logic [127:0] mag128(input logic signed [127:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic qrs_pkg::res_t solve_roots(input logic signed [CW-1:0] a_in,
                                                input logic signed [CW-1:0] b_in,
                                                input logic signed [CW-1:0] c_in);
    qrs_pkg::res_t r;
    logic signed [127:0] a, b, c, d, s;
    logic ovf;
    a = a_in;
    b = b_in;
    c = c_in;
    ovf = 1'b0;
    r = '0;
    if (mag128(a) < coef_tol) begin
      if (mag128(b) < coef_tol) begin
        r.status = mag128(c) < coef_tol ? qrs_pkg::ST_ANY_X : qrs_pkg::ST_NO_ROOT;
      end else begin
        r.status = qrs_pkg::ST_ONE_REAL;
        r.first_real = fx_ratio(-c, b, ovf);
      end
    end else begin
      d = b * b - 4 * a * c;
      if (mag128(d) < disc_tol) begin
        r.status = qrs_pkg::ST_ONE_REAL;
        r.first_real = fx_ratio(-b, 2 * a, ovf);
      end else begin
        s = round_sqrt(mag128(d));
        if (d < 0) begin
          r.status = qrs_pkg::ST_COMPLEX;
          r.first_real = fx_ratio(-b, 2 * a, ovf);
          r.second_real = r.first_real;
          r.first_imag = fx_ratio(-s, 2 * a, ovf);
          r.second_imag = fx_ratio(s, 2 * a, ovf);
        end else begin
          r.status = qrs_pkg::ST_TWO_REAL;
          r.first_real = fx_ratio(-b - s, 2 * a, ovf);
          r.second_real = fx_ratio(-b + s, 2 * a, ovf);
        end
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  // Send one coefficient beat, idling first at random.
  task automatic send_coefs(input logic [CW-1:0] a, input logic [CW-1:0] b,
                            input logic [CW-1:0] c);
    if ($urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    root_queue.push_back(solve_roots(a, b, c));
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Close the current burst and leave a short gap.
  task automatic end_burst();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 8)) @(negedge clk_i);
  endtask

  // Wait until the pipeline is empty, then a latency margin.
  task automatic drain();
    end_burst();
    while (root_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_COEF_TOL) coef_tol = data[TW-1:0];
    else disc_tol = data;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_tolerances(input logic [31:0] ct, input logic [31:0] dt);
    drain();
    write_reg(ADDR_COEF_TOL, ct);
    write_reg(ADDR_DISC_TOL, dt);
  endtask

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      2: return $signed($urandom_range(0, 600)) - 300;
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 200 << FB)) - (100 << FB);
    endcase
  endfunction

  // Corner coefficients and each status code.
  task automatic test_directed();
    logic [CW-1:0] mx, mn, one;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    one = 1 << FB;
    send_coefs(one, -3 * one, 2 * one);  // two real roots
    send_coefs(one, -2 * one, one);      // double root
    send_coefs(one, 0, one);             // complex pair
    send_coefs(0, 0, 0);                 // any x
    send_coefs(0, 0, one);               // no root
    send_coefs(0, 2 * one, one);         // linear
    send_coefs(mx, mx, mx);
    send_coefs(mn, mn, mn);
    send_coefs(mn, mx, mn);
    send_coefs(1, mx, mn);               // saturating roots
    send_coefs(0, 1, mx);                // saturating linear root
    send_coefs(-one, one, one);
    send_coefs('1, '1, '1);
    send_coefs(one, mn, 0);
    drain();
  endtask

  task automatic test_zero_tolerance();
    set_tolerances(0, 0);
    send_coefs(0, 0, 1 << FB);           // zero divisor, zero numerator, positive c
    send_coefs(0, 0, -(1 << FB));        // zero divisor, zero numerator, negative c
    send_coefs(0, 0, 0);
    send_coefs(1 << FB, -2 << FB, 1 << FB);
    for (int i = 0; i < 200; i++) send_coefs(rand_coef(), rand_coef(), rand_coef());
  endtask

  task automatic test_random(input int count, input logic [31:0] ct, input logic [31:0] dt);
    set_tolerances(ct, dt);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 20) == 0) end_burst();
      send_coefs(rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  // Receiver stalls: alternating phases of steady accept and random stall.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready_i <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // Result checker.
  always @(posedge clk_i) begin
    qrs_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (root_queue.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        want = root_queue.pop_front();
        roots_seen++;
        if (want.status <= qrs_pkg::ST_NO_ROOT) status_count[want.status]++;
        if (status_o !== want.status) begin
          $error("status expected %0d got %0d", want.status, status_o);
          errors++;
        end
        if (first_real_o !== want.first_real) begin
          $error("first_real expected %h got %h", want.first_real, first_real_o);
          errors++;
        end
        if (first_imag_o !== want.first_imag) begin
          $error("first_imag expected %h got %h", want.first_imag, first_imag_o);
          errors++;
        end
        if (second_real_o !== want.second_real) begin
          $error("second_real expected %h got %h", want.second_real, second_real_o);
          errors++;
        end
        if (second_imag_o !== want.second_imag) begin
          $error("second_imag expected %h got %h", want.second_imag, second_imag_o);
          errors++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow expected %0d got %0d", want.overflow, overflow_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or configuration access.
  always @(posedge clk_i) begin
    int idle;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) idle = 0;
    else idle++;
    if (idle >= STALL_LIMIT && !stim_done) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    coef_tol = 1;
    disc_tol = 4295;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500, 1, 4295);
    test_zero_tolerance();
    test_random(400, 16'hFFFF, 32'hFFFF_FFFF);
    test_random(300, 300, 1 << 20);
    test_random(350, 2, 0);
    drain();
    stim_done = 1'b1;
    $display("Sent %0d coefficient beats, checked %0d results.", beats_sent, roots_seen);
    $display("Status mix: two %0d, one %0d, complex %0d, any %0d, none %0d.",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4]);
    if (errors == 0 && root_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[quadratic_root_solver.f]
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver.sv
bench/quadratic_root_solver_test.sv
